@@ src/next_fit_id_allocator_top_macros.svh @@
// Assertion macros used by the allocator top level.
`ifndef NEXT_FIT_ID_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_ID_ALLOCATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge out of reset.
`define NFA_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("allocator check failed");
// Checks that a trigger implies a consequence in the same cycle.
`define NFA_ASSERT_IMPLY(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error("allocator check failed");
`else
`define NFA_ASSERT_ALWAYS(label, cond)
`define NFA_ASSERT_IMPLY(label, trig, cons)
`endif
`endif

@@ src/nfa_pkg.sv @@
// Types, constants and helper functions of the next-fit identifier allocator.
package nfa_pkg;

   // The in-use map is held in words of this many slots.
   localparam int WORD_BITS = 8;
   localparam int BIT_W = $clog2(WORD_BITS);

   // Depth of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] BASE_ID_RESET = 16'd300;

   typedef enum logic {
      CMD_ALLOCATE = 1'b0,
      CMD_RELEASE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_RANGE     = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   // Class of an item as sorted by the front.
   typedef enum logic [1:0] {
      CLS_ALLOC,
      CLS_RELEASE,
      CLS_RANGE
   } cls_type;

   typedef struct packed {
      cls_type     cls;
      logic [15:0] offset;
   } entry_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_REL_CHK,
      BK_SCAN_CHK
   } back_state_type;

   // Status that the back reports to the rest of the block.
   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Index of the lowest set bit; zero when no bit is set.
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (v[b]) begin
            idx = BIT_W'(b);
         end
      end
      return idx;
   endfunction

endpackage

@@ src/nfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/nfa_front.sv @@
// Front of the allocator: accepts items and sorts them for the back.
module nfa_front import nfa_pkg::*; #(
   parameter int POOL_SIZE = 256
) (
   input  logic            start,
   output logic            busy,
   input  logic            req_command,
   input  logic [15:0]     req_release_id,
   input  logic [15:0]     base_id,
   input  logic            queue_full,
   input  back_status_type back_status,
   output logic            push,
   output entry_type       push_entry
);

   logic [15:0] offset;
   logic        in_range;

   // No item is taken while the map is being cleared or the queue is full.
   assign busy = back_status.clearing | queue_full;
   assign push = start & ~busy;

   // The range check wraps modulo 2^16, as the identifiers do.
   assign offset   = req_release_id - base_id;
   assign in_range = 32'(offset) < 32'(POOL_SIZE);

   always_comb begin
      push_entry.offset = offset;
      if (req_command == CMD_RELEASE) begin
         push_entry.cls = in_range ? CLS_RELEASE : CLS_RANGE;
      end else begin
         push_entry.cls = CLS_ALLOC;
      end
   end

endmodule

@@ src/nfa_queue.sv @@
// Short queue of sorted items between the front and the back.
module nfa_queue import nfa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = cnt_ff == '0;
   assign full    = cnt_ff == CNT_W'(QUEUE_DEPTH);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slots_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ src/nfa_back.sv @@
// Back of the allocator: owns the in-use map and carries out each item.
module nfa_back import nfa_pkg::*; #(
   parameter int POOL_SIZE = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [15:0]     base_id,
   input  logic            queue_empty,
   input  entry_type       queue_head,
   output logic            queue_pop,
   output back_status_type back_status,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [15:0]     rsp_granted_id
);

   localparam int DEPTH   = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W  = $clog2(POOL_SIZE);
   localparam int COUNT_W = $clog2(POOL_SIZE + 1);
   localparam int VISIT_W = $clog2(DEPTH + 1);

   back_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]    ptr_ff, ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic [VISIT_W-1:0]   visit_ff, visit_in;
   logic                 first_ff, first_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_id_ff, rsp_id_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   logic [SLOT_W-1:0]    head_slot;
   logic [31:0]          head32, ptr32, word32, rel32, found32, next32;
   logic [WORD_BITS-1:0] valid_mask, low_mask, cand;
   logic                 found, pool_full;
   logic [BIT_W-1:0]     found_bit;
   logic [SLOT_W-1:0]    found_slot, next_ptr;
   logic [ADDR_W-1:0]    next_word;

   nfa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(DEPTH)
   ) u_map (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // Slot and word positions of the queue head, the pointer and the scan.
   assign head_slot = queue_head.offset[SLOT_W-1:0];
   assign head32    = 32'(head_slot);
   assign ptr32     = 32'(ptr_ff);
   assign word32    = 32'(word_ff);
   assign rel32     = 32'(slot_ff);
   assign pool_full = 32'(count_ff) >= 32'(POOL_SIZE);

   // Free slots of the word in hand; slots past the pool never count as free.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = ((word32 << BIT_W) | 32'(b)) < 32'(POOL_SIZE);
      end
      low_mask = first_ff ? ({WORD_BITS{1'b1}} << ptr32[BIT_W-1:0]) : {WORD_BITS{1'b1}};
      cand      = ~ram_rdata & valid_mask & low_mask;
      found     = |cand;
      found_bit = first_set(cand);
      found32   = (word32 << BIT_W) | 32'(found_bit);
      found_slot = found32[SLOT_W-1:0];
      next32    = found32 + 32'd1;
      next_ptr  = (next32 == 32'(POOL_SIZE)) ? '0 : next32[SLOT_W-1:0];
      next_word = (word32 + 32'd1 == 32'(DEPTH)) ? '0 : word_ff + ADDR_W'(1);
   end

   assign back_status.clearing = state_ff == BK_CLEAR;

   // Sequencer: clearing pass, then one item at a time from the queue.
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      word_in       = word_ff;
      visit_in      = visit_ff;
      first_in      = first_ff;
      slot_in       = slot_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      queue_pop     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = word_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = word_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (32'(clr_ff) == 32'(DEPTH - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               case (queue_head.cls)
                  CLS_RANGE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                     rsp_id_in     = '0;
                  end
                  CLS_RELEASE: begin
                     ram_raddr = head32[BIT_W +: ADDR_W];
                     slot_in   = head_slot;
                     state_in  = BK_REL_CHK;
                  end
                  default: begin
                     if (pool_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                        rsp_id_in     = '0;
                     end else begin
                        ram_raddr = ptr32[BIT_W +: ADDR_W];
                        word_in   = ptr32[BIT_W +: ADDR_W];
                        first_in  = 1'b1;
                        visit_in  = '0;
                        state_in  = BK_SCAN_CHK;
                     end
                  end
               endcase
            end
         end
         BK_REL_CHK: begin
            // The word of the released slot is on the read port now.
            rsp_valid_in = 1'b1;
            rsp_id_in    = '0;
            state_in     = BK_IDLE;
            if (ram_rdata[rel32[BIT_W-1:0]]) begin
               ram_we        = 1'b1;
               ram_waddr     = rel32[BIT_W +: ADDR_W];
               ram_wdata     = ram_rdata & ~(WORD_BITS'(1) << rel32[BIT_W-1:0]);
               rsp_status_in = ST_OK;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end else begin
               rsp_status_in = ST_NOT_ALLOC;
            end
         end
         BK_SCAN_CHK: begin
            if (found) begin
               ram_we        = 1'b1;
               ram_waddr     = word_ff;
               ram_wdata     = ram_rdata | (WORD_BITS'(1) << found_bit);
               count_in      = count_ff + COUNT_W'(1);
               ptr_in        = next_ptr;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_id_in     = base_id + 16'(found_slot);
               state_in      = BK_IDLE;
            end else if (visit_ff == VISIT_W'(DEPTH)) begin
               // Every word, and the head of the first one again, has been seen.
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_id_in     = '0;
               state_in      = BK_IDLE;
            end else begin
               ram_raddr = next_word;
               word_in   = next_word;
               first_in  = 1'b0;
               visit_in  = visit_ff + VISIT_W'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         ptr_ff       <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan position and result payload.
   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      visit_ff      <= visit_in;
      first_ff      <= first_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_granted_id = rsp_id_ff;

endmodule

@@ src/next_fit_id_allocator_top.sv @@
// Top level of the next-fit identifier allocator.
// Results are registered. A release reads the map word of its slot, then clears the bit if set;
// an allocate reads map words from the next-fit pointer on, one word per cycle, until it finds
// a free slot or has seen every word. A full pool and an out-of-range release are answered from
// the idle state without a map read. The back takes one item at a time; a two-item queue lets start run ahead.
// Reset is synchronous; afterwards a clearing pass that zeroes every map word holds busy.
`include "next_fit_id_allocator_top_macros.svh"
module next_fit_id_allocator_top import nfa_pkg::*; #(
   parameter int POOL_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_release_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_id,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0]     base_id_ff, base_id_in;
   logic            queue_full, queue_empty, queue_push, queue_pop;
   entry_type       push_entry, queue_head;
   back_status_type back_status;

   // Base identifier register.
   assign base_id_in = csr_we ? csr_wdata : base_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff <= BASE_ID_RESET;
      end else begin
         base_id_ff <= base_id_in;
      end
   end

   nfa_front #(
      .POOL_SIZE(POOL_SIZE)
   ) u_front (
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_release_id(req_release_id),
      .base_id       (base_id_ff),
      .queue_full    (queue_full),
      .back_status   (back_status),
      .push          (queue_push),
      .push_entry    (push_entry)
   );

   nfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_entry(push_entry),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   nfa_back #(
      .POOL_SIZE(POOL_SIZE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .base_id       (base_id_ff),
      .queue_empty   (queue_empty),
      .queue_head    (queue_head),
      .queue_pop     (queue_pop),
      .back_status   (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_granted_id(rsp_granted_id)
   );

   // No item may enter and no result may leave while the map is cleared.
   `NFA_ASSERT_IMPLY(a_busy_while_clearing, back_status.clearing, busy)
   `NFA_ASSERT_IMPLY(a_no_result_while_clearing, back_status.clearing, !rsp_valid)
   // Only a successful allocate carries a non-zero identifier.
   `NFA_ASSERT_IMPLY(a_failed_id_zero, rsp_valid && rsp_status != ST_OK, rsp_granted_id == 16'd0)
   // The queue holds no items while the map is being cleared.
   `NFA_ASSERT_ALWAYS(a_queue_empty_when_clearing, !back_status.clearing || queue_empty)

endmodule
